// ===== hdl/stcd_pkg.sv =====
package stcd_pkg;

   // field widths fixed by the transaction format
   localparam int ROW_W       = 6;
   localparam int COL_W       = 6;
   localparam int WORD_W      = 32;
   localparam int COL_COUNT_W = 7;
   localparam int PIT_W       = 8;
   localparam int TW_W        = 9;
   localparam int BPP_W       = 3;
   localparam int STEP_W      = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // defaults for top-level parameters
   localparam int DEF_MAX_TILE_COLUMNS = 64;
   localparam int DEF_MAX_TILE_ROWS    = 64;
   localparam int MAP_ROWS_LIMIT       = 64;   // rows reachable with a 6-bit tile_row

   localparam int OP_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [TW_W-1:0]  TILE_WIDTH_RST = TW_W'(32);
   localparam logic [BPP_W-1:0] BPP_RST        = BPP_W'(4);
   localparam logic [TW_W-1:0]  TILE_WIDTH_MIN = TW_W'(4);
   localparam logic [TW_W-1:0]  TILE_WIDTH_MAX = TW_W'(256);

   // register select, taken from paddr[2]
   localparam logic REG_TILE_WIDTH = 1'b0;
   localparam logic REG_BPP        = 1'b1;

   // func codes
   localparam logic FUNC_PROBE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // back-end operation kinds
   localparam logic OP_SET   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic              func;
      logic              first_of_line;
      logic [ROW_W-1:0]  tile_row;
      logic [COL_W-1:0]  clear_column;
      logic [WORD_W-1:0] new_word;
      logic [WORD_W-1:0] old_word;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] copy_column;
      logic [ROW_W-1:0] copy_row;
   } rsp_type;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } op_type;

   // pixels per 32-bit word; odd codes folded as the block defines
   function automatic logic [STEP_W-1:0] pixel_step(input logic [BPP_W-1:0] bpp);
      logic [STEP_W-1:0] s;
      case (bpp)
         3'd0:    s = 3'd4;
         3'd1:    s = 3'd4;
         3'd2:    s = 3'd2;
         default: s = 3'd1;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/stcd_ram.sv =====
module stcd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and a write to one address in a cycle returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/stcd_fifo.sv =====
module stcd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output logic [WIDTH-1:0]             out_data,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign count     = count_ff;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/stcd_front.sv =====
module stcd_front #(
   parameter int MAX_TILE_COLUMNS = stcd_pkg::DEF_MAX_TILE_COLUMNS,
   parameter int MAX_TILE_ROWS    = stcd_pkg::DEF_MAX_TILE_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  stcd_pkg::req_type             req_data,
   input  logic [stcd_pkg::TW_W-1:0]     tile_width,
   input  logic [stcd_pkg::BPP_W-1:0]    pixel_bytes,
   output logic                          op_push,
   output stcd_pkg::op_type              op_data
);

   import stcd_pkg::*;

   logic [COL_COUNT_W-1:0] col_ff, col_in, col_base;
   logic [PIT_W-1:0]       pit_ff, pit_in, pit_base;
   logic [TW_W-1:0]        eff_tw, next_pit;
   logic                   row_ok, col_ok, clr_col_ok, is_clear;

   always_comb begin
      if (tile_width < TILE_WIDTH_MIN) begin
         eff_tw = TILE_WIDTH_MIN;
      end else if (tile_width > TILE_WIDTH_MAX) begin
         eff_tw = TILE_WIDTH_MAX;
      end else begin
         eff_tw = tile_width;
      end
   end

   assign is_clear   = (req_data.func == FUNC_CLEAR);
   assign col_base   = req_data.first_of_line ? '0 : col_ff;
   assign pit_base   = req_data.first_of_line ? '0 : pit_ff;
   assign next_pit   = {1'b0, pit_base} + TW_W'(pixel_step(pixel_bytes));
   assign row_ok     = (int'(req_data.tile_row) < MAX_TILE_ROWS);
   assign col_ok     = (int'(col_base) < MAX_TILE_COLUMNS);
   assign clr_col_ok = (int'(req_data.clear_column) < MAX_TILE_COLUMNS);

   // counters move on probes only
   always_comb begin
      col_in = col_ff;
      pit_in = pit_ff;
      if (req_fire && !is_clear) begin
         if (next_pit >= eff_tw) begin
            pit_in = '0;
            col_in = col_ok ? col_base + 1'b1 : col_base;
         end else begin
            pit_in = next_pit[PIT_W-1:0];
            col_in = col_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         pit_ff <= '0;
      end else begin
         col_ff <= col_in;
         pit_ff <= pit_in;
      end
   end

   // only transactions that can touch the map go to the back end
   always_comb begin
      op_data.kind = is_clear ? OP_CLEAR : OP_SET;
      op_data.row  = req_data.tile_row;
      op_data.col  = is_clear ? req_data.clear_column : col_base[COL_W-1:0];
      if (is_clear) begin
         op_push = req_fire && row_ok && clr_col_ok;
      end else begin
         op_push = req_fire && row_ok && col_ok &&
                   (req_data.new_word != req_data.old_word);
      end
   end

endmodule

// ===== hdl/stcd_back.sv =====
module stcd_back #(
   parameter int MAX_TILE_COLUMNS = stcd_pkg::DEF_MAX_TILE_COLUMNS,
   parameter int MAX_TILE_ROWS    = stcd_pkg::DEF_MAX_TILE_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  stcd_pkg::op_type  op_data,
   output logic              op_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stcd_pkg::rsp_type rsp_data
);

   import stcd_pkg::*;

   localparam int MAP_DEPTH = (MAX_TILE_ROWS < MAP_ROWS_LIMIT) ? MAX_TILE_ROWS
                                                               : MAP_ROWS_LIMIT;
   localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int MAP_W     = MAX_TILE_COLUMNS;
   localparam int RCNT_W    = $clog2(RSP_QUEUE_DEPTH+1);

   logic [MAP_DEPTH-1:0] row_valid_ff, row_valid_in;
   logic                 stg_v_ff;
   op_type               stg_op_ff;
   logic                 stg_rv_ff;
   logic                 fwd_v_ff;
   logic [ADDR_W-1:0]    fwd_row_ff;
   logic [MAP_W-1:0]     fwd_data_ff;

   logic [ADDR_W-1:0]    iss_addr, stg_addr;
   logic [MAP_W-1:0]     ram_rdata, cur_row, new_row, mask;
   logic                 hit, rsp_push, rsp_pop, rsp_full;
   logic [RCNT_W-1:0]    rsp_count;
   logic [RCNT_W:0]      occ_next;
   rsp_type              rsp_push_data;

   assign iss_addr = op_data.row[ADDR_W-1:0];
   assign stg_addr = stg_op_ff.row[ADDR_W-1:0];

   // issue only when the result queue is sure to have room for the outcome
   assign rsp_pop  = rsp_valid && rsp_ready;
   assign occ_next = {1'b0, rsp_count} + (RCNT_W+1)'(rsp_push) - (RCNT_W+1)'(rsp_pop);
   assign op_pop   = op_valid && (occ_next < (RCNT_W+1)'(RSP_QUEUE_DEPTH));

   stcd_ram #(
      .WIDTH (MAP_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (stg_v_ff),
      .wr_addr (stg_addr),
      .wr_data (new_row),
      .rd_en   (op_pop),
      .rd_addr (iss_addr),
      .rd_data (ram_rdata)
   );

   // the write made while this row was being read is not in the RAM output
   always_comb begin
      mask = MAP_W'(1) << stg_op_ff.col;
      if (fwd_v_ff && (fwd_row_ff == stg_addr)) begin
         cur_row = fwd_data_ff;
      end else if (stg_rv_ff) begin
         cur_row = ram_rdata;
      end else begin
         cur_row = '0;
      end
      hit = ((cur_row & mask) == '0);
      if (stg_op_ff.kind == OP_CLEAR) begin
         new_row  = cur_row & ~mask;
         rsp_push = 1'b0;
      end else begin
         new_row  = cur_row | mask;
         rsp_push = stg_v_ff && hit;
      end
      rsp_push_data.copy_column = stg_op_ff.col;
      rsp_push_data.copy_row    = stg_op_ff.row;
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (stg_v_ff) begin
         row_valid_in[stg_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         stg_v_ff     <= 1'b0;
         fwd_v_ff     <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         stg_v_ff     <= op_pop;
         fwd_v_ff     <= stg_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      stg_op_ff   <= op_data;
      stg_rv_ff   <= row_valid_ff[iss_addr];
      fwd_row_ff  <= stg_addr;
      fwd_data_ff <= new_row;
   end

   stcd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_data),
      .pop       (rsp_pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (rsp_full),
      .count     (rsp_count)
   );

   // issue gating keeps the queue from overflowing; full is only a backstop
   logic unused_full;
   assign unused_full = rsp_full;

endmodule

// ===== hdl/scanline_tile_change_detector_core.sv =====
// Scanline tile change detector. Each req transaction carries one 32-bit word of a freshly
// read scanline, the matching stored framebuffer word and the tile row; the block follows
// the tile column with its own counters (restarted by first_of_line) and, the first time a
// word differs inside an unmarked tile, marks that tile dirty and returns one rsp
// transaction with its column and row. func=1 unmarks one tile instead. One transaction is
// accepted every clock while req_ready is high; a copy request reaches rsp through the
// operation queue, the dirty-map RAM read, its read-modify-write stage and the result
// queue. req_ready drops only when the two-entry operation queue is full, i.e. rsp stalled.
// Registers: tile_width at 0x0, pixel_bytes at 0x4; write them only while the block is idle.
// The dirty map is cleared at reset by per-row valid bits, so no clearing pass is needed.
module scanline_tile_change_detector_core #(
   parameter int MAX_TILE_COLUMNS = stcd_pkg::DEF_MAX_TILE_COLUMNS,
   parameter int MAX_TILE_ROWS    = stcd_pkg::DEF_MAX_TILE_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  stcd_pkg::req_type                 req_data,
   // copy-request channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output stcd_pkg::rsp_type                 rsp_data,
   // APB-style register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [stcd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [stcd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [stcd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import stcd_pkg::*;

   localparam int OCNT_W = $clog2(OP_QUEUE_DEPTH+1);

   // ---------------------------------------------------------------------
   // Registers. Only paddr[2] selects; the low address bits are ignored.
   // ---------------------------------------------------------------------
   logic [TW_W-1:0]  tile_width_ff;
   logic [BPP_W-1:0] bpp_ff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff <= TILE_WIDTH_RST;
         bpp_ff        <= BPP_RST;
      end else if (csr_wr) begin
         if (paddr[2] == REG_TILE_WIDTH) begin
            tile_width_ff <= pwdata[TW_W-1:0];
         end else begin
            bpp_ff <= pwdata[BPP_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_TILE_WIDTH) begin
         prdata = CSR_DATA_W'(tile_width_ff);
      end else begin
         prdata = CSR_DATA_W'(bpp_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Front: column tracking and classification. Every transaction is taken
   // here; those that cannot change the map (equal words, row or column out
   // of range) end at this point, the rest become set/clear operations.
   // ---------------------------------------------------------------------
   logic    req_fire, op_push, op_full, op_valid, op_pop;
   op_type  op_in, op_out;
   logic [OCNT_W-1:0] op_count;

   assign req_ready = !op_full;
   assign req_fire  = req_valid && req_ready;

   stcd_front #(
      .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
      .MAX_TILE_ROWS    (MAX_TILE_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .tile_width  (tile_width_ff),
      .pixel_bytes (bpp_ff),
      .op_push     (op_push),
      .op_data     (op_in)
   );

   // short queue decoupling the front from the map update
   stcd_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .pop       (op_pop),
      .out_valid (op_valid),
      .out_data  (op_out),
      .full      (op_full),
      .count     (op_count)
   );

   // ---------------------------------------------------------------------
   // Back: dirty-map read, test-and-set or clear, write back, and the
   // result queue that feeds rsp.
   // ---------------------------------------------------------------------
   stcd_back #(
      .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
      .MAX_TILE_ROWS    (MAX_TILE_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_data   (op_out),
      .op_pop    (op_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // occupancy of the operation queue is not needed beyond full/valid
   logic unused_count;
   assign unused_count = ^op_count;

endmodule
